// ===== hw/rtl/tle_pkg.sv =====
`default_nettype none

package tle_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 6;

    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // control characters
    localparam byte_t CH_DEL = 8'h7F;
    localparam byte_t CH_CR  = 8'h0D;
    localparam byte_t CH_LF  = 8'h0A;
    localparam byte_t CH_BS  = 8'h08;
    localparam byte_t CH_SP  = 8'h20;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic echo_emit;
        logic space_emit;
        logic line_emit;
        logic mark_emit;
    } tle_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic echo_left;
        logic need_space;
        logic need_end;
        logic line_empty;
        logic rd_last;
    } tle_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tle_if.sv =====
`default_nettype none

// received byte channel
interface tle_in_if import tle_pkg::*;;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface tle_out_if import tle_pkg::*;;
    logic  valid;
    logic  ready;
    kind_t kind;
    byte_t data_byte;
    len_t  line_length;
    logic  last;

    modport source (output valid, output kind, output data_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input line_length,
                    input last, output ready);
endinterface

// echo enable write channel
interface tle_cfg_if;
    logic valid;
    logic ready;
    logic echo_enable;

    modport source (output valid, output echo_enable, input ready);
    modport sink   (input valid, input echo_enable, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/terminal_line_editor.sv =====
`default_nettype none

// Line editor for a serial console receiver. Each received byte on in_ch may
// produce echo items (CR gives CR CR LF, DEL gives BS SP BS), and a CR or LF
// ends the line: the stored bytes then come out on out_ch in order, followed
// by an end marker with the length. DEL at an empty line yields one space
// item even with echo off; a byte arriving at a full line ends the line and
// is dropped. echo_enable is written on cfg_ch and resets to 1. One byte is
// handled at a time. Echo items and line bytes each leave one result per
// cycle while out_ch is ready, from the single output register and the line
// store's read port; stalls on out_ch hold them. The next byte is taken while
// the last result still waits in the output register.
module terminal_line_editor import tle_pkg::*; #(
    parameter int MAX_LINE = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tle_in_if.sink    in_ch,
    tle_out_if.source out_ch,
    tle_cfg_if.sink   cfg_ch
);

    tle_cmd_t    cmd;
    tle_status_t status;

    // the register write is always taken
    assign cfg_ch.ready = 1'b1;

    // sequencer
    tle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // line store, counters and output register
    tle_datapath #(
        .MAX_LINE (MAX_LINE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_ch.rx_byte),
        .cfg_write (cfg_ch.valid),
        .cfg_echo  (cfg_ch.echo_enable),
        .cmd       (cmd),
        .status    (status),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tle_ram.sv =====
`default_nettype none

module tle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tle_ctrl.sv =====
`default_nettype none

module tle_ctrl import tle_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire tle_status_t status,
    output tle_cmd_t         cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ECHO  = 6'b000010,
        S_SPACE = 6'b000100,
        S_DUMP  = 6'b001000,
        S_MARK  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // sequencing of the results of one item
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.accept     = in_valid && in_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_ECHO;
                end
            end
            S_ECHO:
            begin
                if (status.echo_left)
                begin
                    cmd.echo_emit = status.out_free;
                end
                else if (status.need_space)
                begin
                    state_next = S_SPACE;
                end
                else if (status.need_end)
                begin
                    state_next = status.line_empty ? S_MARK : S_DUMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPACE:
            begin
                if (status.out_free)
                begin
                    cmd.space_emit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (status.out_free)
                begin
                    cmd.line_emit = 1'b1;
                    if (status.rd_last)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.mark_emit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // at most one result loaded per cycle
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.echo_emit, cmd.space_emit, cmd.line_emit, cmd.mark_emit}))
        else $error("more than one result loaded in a cycle");

    // a result is loaded only into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.echo_emit || cmd.space_emit || cmd.line_emit || cmd.mark_emit)
        |-> status.out_free)
        else $error("result loaded while output register busy");

    // after an accepted item the echo phase follows
    a_accept_echo: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_ECHO))
        else $error("accepted item not followed by echo phase");

endmodule

`default_nettype wire

// ===== hw/rtl/tle_datapath.sv =====
`default_nettype none

module tle_datapath import tle_pkg::*; #(
    parameter int MAX_LINE = 32,
    parameter int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire byte_t    in_byte,
    input  wire logic     cfg_write,
    input  wire logic     cfg_echo,
    input  wire tle_cmd_t cmd,
    output tle_status_t   status,
    tle_out_if.source     out_ch
);

    logic        echo_en_reg;
    len_t        count_reg;
    len_t        count_next;
    byte_t       byte_reg;
    logic [1:0]  echo_step_reg;
    logic [1:0]  echo_cnt_reg;
    logic        space_reg;
    logic        end_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_idx_next;
    byte_t       rd_data;

    logic        out_valid_reg;
    kind_t       out_kind_reg;
    byte_t       out_data_reg;
    len_t        out_len_reg;
    logic        out_last_reg;

    // decode of the incoming byte against the current line
    logic in_cr;
    logic in_del;
    logic in_lf;
    logic full;
    logic end_now;
    logic del_now;
    logic store_now;

    assign in_cr     = (in_byte == CH_CR);
    assign in_del    = (in_byte == CH_DEL);
    assign in_lf     = in_cr || (in_byte == CH_LF);
    assign full      = (count_reg >= LEN_W'(MAX_LINE));
    assign end_now   = in_lf || full;
    assign del_now   = !end_now && in_del;
    assign store_now = !end_now && !in_del;

    // line store
    tle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.accept && store_now),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_byte),
        .raddr (rd_idx_next),
        .rdata (rd_data)
    );

    // status toward the controller
    logic echo_last;
    assign echo_last = ((echo_step_reg + 2'd1) == echo_cnt_reg) && !space_reg && !end_reg;

    always_comb
    begin
        status.out_free   = !out_valid_reg || out_ch.ready;
        status.echo_left  = (echo_step_reg != echo_cnt_reg);
        status.need_space = space_reg;
        status.need_end   = end_reg;
        status.line_empty = (count_reg == '0);
        status.rd_last    = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == count_reg);
    end

    // echo byte for the current step
    byte_t echo_byte;
    always_comb
    begin
        if (byte_reg == CH_CR)
        begin
            echo_byte = (echo_step_reg == 2'd2) ? CH_LF : CH_CR;
        end
        else if (byte_reg == CH_DEL)
        begin
            echo_byte = (echo_step_reg == 2'd1) ? CH_SP : CH_BS;
        end
        else
        begin
            echo_byte = byte_reg;
        end
    end

    // line count update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.accept && del_now && (count_reg != '0))
        begin
            count_next = count_reg - LEN_W'(1);
        end
        else if (cmd.accept && store_now)
        begin
            count_next = count_reg + LEN_W'(1);
        end
        else if (cmd.mark_emit)
        begin
            count_next = '0;
        end
    end

    // read index walks the line during the dump
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.line_emit)
        begin
            rd_idx_next = status.rd_last ? '0 : rd_idx_reg + ADDR_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg   <= 1'b1;
            count_reg     <= '0;
            echo_step_reg <= '0;
            echo_cnt_reg  <= '0;
            space_reg     <= 1'b0;
            end_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                echo_en_reg <= cfg_echo;
            end
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            if (cmd.accept)
            begin
                echo_step_reg <= '0;
                if (!echo_en_reg)
                begin
                    echo_cnt_reg <= 2'd0;
                end
                else if (in_cr || in_del)
                begin
                    echo_cnt_reg <= 2'd3;
                end
                else
                begin
                    echo_cnt_reg <= 2'd1;
                end
                space_reg <= del_now && (count_reg == '0);
                end_reg   <= end_now;
            end
            else if (cmd.echo_emit)
            begin
                echo_step_reg <= echo_step_reg + 2'd1;
            end
            if (cmd.echo_emit || cmd.space_emit || cmd.line_emit || cmd.mark_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_byte;
        end
        if (cmd.echo_emit)
        begin
            out_kind_reg <= KIND_ECHO;
            out_data_reg <= echo_byte;
            out_len_reg  <= '0;
            out_last_reg <= echo_last;
        end
        else if (cmd.space_emit)
        begin
            out_kind_reg <= KIND_ECHO;
            out_data_reg <= CH_SP;
            out_len_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.line_emit)
        begin
            out_kind_reg <= KIND_LINE;
            out_data_reg <= rd_data;
            out_len_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.mark_emit)
        begin
            out_kind_reg <= KIND_END;
            out_data_reg <= '0;
            out_len_reg  <= count_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.data_byte   = out_data_reg;
    assign out_ch.line_length = out_len_reg;
    assign out_ch.last        = out_last_reg;

    // line never grows past its limit
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(MAX_LINE))
        else $error("line count above limit");

    // the end marker clears the line
    a_mark_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_emit |=> (count_reg == '0))
        else $error("line not cleared after end marker");

    // line bytes come only from a non-empty line
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.line_emit |-> (count_reg != '0))
        else $error("line byte emitted from an empty line");

endmodule

`default_nettype wire
